>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/core/hist1d_pkg.sv
// ----------------------------------------------------------------------------
// hist1d_pkg
// Shared types and constants of the 1-D histogram engine.
// ----------------------------------------------------------------------------
package hist1d_pkg;
   localparam int MaxBins = 256;
   localparam int Cells   = MaxBins + 2;
   localparam int AddrW   = $clog2(Cells);
   localparam int DivW    = 25; // numerator width: 9 + 16 bits

   localparam logic [2:0] REQ_FILL  = 3'd0;
   localparam logic [2:0] REQ_SET   = 3'd1;
   localparam logic [2:0] REQ_READ  = 3'd2;
   localparam logic [2:0] REQ_MAX   = 3'd3;
   localparam logic [2:0] REQ_CLEAR = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_CFG   = 2'd2;

   localparam logic [1:0] CSR_XMIN   = 2'd0;
   localparam logic [1:0] CSR_XMAX   = 2'd1;
   localparam logic [1:0] CSR_NBINS  = 2'd2;
   localparam logic [1:0] CSR_THRESH = 2'd3;

   typedef enum logic [3:0] {
      CMD_NONE, CMD_LOAD, CMD_DIV, CMD_RDBIN, CMD_FILLWR, CMD_SETWR,
      CMD_READOUT, CMD_MAXRD, CMD_CLRWR, CMD_DIRECT
   } cmd_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [AddrW-1:0]   addr;
   } ctl_type;

   typedef struct packed {
      logic [2:0]  req;
      logic        early;      // result known without store access
      logic        div_done;
      logic [AddrW-1:0] fill_bin;
   } sts_type;
endpackage

>>> rtl/core/histogram_1d_engine_top.sv
// ----------------------------------------------------------------------------
// histogram_1d_engine_top
// One-dimensional histogram engine with fill, set, read, max search and clear.
// ----------------------------------------------------------------------------
// Usage: drive one request item on req_* (tuser = request kind, tdata = the
// operand fields); each item yields one result item on rsp_* (tuser = status).
// Items are handled one at a time: req_tready is high only while idle with
// no result waiting, so the next item is taken in the cycle after the result
// has been delivered.
// Work per request kind:
//   fill with a valid coordinate: 25-step restoring divider
//   max bin: one store read per cell
//   clear: one store write per cell over all 258 cells
// The result register holds the item while rsp_tready is low.
// Reset clears the fill count and control, then a clearing pass zeroes all
// 258 cells while req_tready stays low.
// Configuration writes on csr_* may only occur while no request is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module histogram_1d_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // req_type
   input  logic [79:0] req_tdata,   // x_coord, weight, bin_index, set_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // result_bin, content, entry_count
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   logic signed [15:0] x_min_ff, x_max_ff;
   logic [8:0]         num_bins_ff;
   logic signed [31:0] threshold_ff;
   hist1d_pkg::ctl_type ctl;
   hist1d_pkg::sts_type sts;
   logic busy, rsp_load, req_fire, valid_ff;
   logic [8:0] o_bin;
   logic signed [31:0] o_content;
   logic [31:0] o_count;
   logic [1:0] o_status;

   // hold the input while busy or while a result waits
   assign req_tready = !busy && !valid_ff;
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff <= 16'sd0; x_max_ff <= 16'sd32767;
         num_bins_ff <= 9'd256; threshold_ff <= 32'sd0;
      end else if (csr_we) begin
         case (csr_index)
            hist1d_pkg::CSR_XMIN:   x_min_ff <= csr_data[15:0];
            hist1d_pkg::CSR_XMAX:   x_max_ff <= csr_data[15:0];
            hist1d_pkg::CSR_NBINS:  num_bins_ff <= csr_data[8:0];
            hist1d_pkg::CSR_THRESH: threshold_ff <= csr_data;
            default: ;
         endcase
      end
   end

   hist1d_ctl u_ctl (
      .clock, .reset, .req_fire, .busy, .rsp_load, .rsp_free(!valid_ff),
      .num_bins(num_bins_ff), .idx(req_tdata[40:32]), .sts, .ctl
   );

   hist1d_dp u_dp (
      .clock, .reset, .ctl, .sts,
      .in_req(req_tuser), .in_x(req_tdata[15:0]), .in_w(req_tdata[31:16]),
      .in_idx(req_tdata[40:32]), .in_sv(req_tdata[72:41]),
      .x_min(x_min_ff), .x_max(x_max_ff), .num_bins(num_bins_ff),
      .threshold(threshold_ff),
      .out_bin(o_bin), .out_content(o_content), .out_count(o_count),
      .out_status(o_status)
   );

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (rsp_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, o_count, o_content, o_bin};
   assign rsp_tuser  = o_status;

   `ASSERT_IMPL(a_busy_rsp, clock, reset, rsp_tvalid, !req_tready)
   `ASSERT_NEXT(a_load_valid, clock, reset, rsp_load, rsp_tvalid)
   `ASSERT_IMPL(a_fire_idle, clock, reset, req_fire, !rsp_tvalid)
endmodule

>>> rtl/core/hist1d_ram.sv
// ----------------------------------------------------------------------------
// hist1d_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module hist1d_ram #(
   parameter int Width = 32,
   parameter int Depth = 258
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

>>> rtl/core/hist1d_dp.sv
// ----------------------------------------------------------------------------
// hist1d_dp
// Datapath: request latch, bin divider, bin store and result register.
// ----------------------------------------------------------------------------
module hist1d_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  hist1d_pkg::ctl_type   ctl,
   output hist1d_pkg::sts_type   sts,
   input  logic [2:0]            in_req,
   input  logic signed [15:0]    in_x,
   input  logic signed [15:0]    in_w,
   input  logic [8:0]            in_idx,
   input  logic signed [31:0]    in_sv,
   input  logic signed [15:0]    x_min,
   input  logic signed [15:0]    x_max,
   input  logic [8:0]            num_bins,
   input  logic signed [31:0]    threshold,
   output logic [8:0]            out_bin,
   output logic signed [31:0]    out_content,
   output logic [31:0]           out_count,
   output logic [1:0]            out_status
);
   localparam int AW = hist1d_pkg::AddrW;
   localparam int DW = hist1d_pkg::DivW;

   logic [2:0]  req_ff;
   logic signed [15:0] w_ff;
   logic [8:0]  idx_ff;
   logic signed [31:0] sv_ff;
   logic        early_ff;
   logic [DW-1:0] quo_ff, rem_ff, num_ff;
   logic [16:0] den_ff;
   logic [4:0]  step_ff;
   logic [31:0] count_ff;
   logic [8:0]  bin_ff;
   logic signed [31:0] content_ff;
   logic [1:0]  status_ff;
   logic [8:0]  best_bin_ff;
   logic signed [31:0] best_ff;
   logic [AW-1:0] scan_ff;

   logic        ram_we;
   logic [AW-1:0] ram_addr;
   logic [31:0] ram_wd, ram_rd;

   logic        nb_ok;
   logic [9:0]  ncells;
   logic signed [16:0] dx, span;
   logic [DW:0] trial;
   logic [AW-1:0] fbin;
   logic signed [32:0] sum;
   logic signed [31:0] satv;

   assign nb_ok  = (num_bins >= 9'd1) && ({1'b0, num_bins} <= 10'(hist1d_pkg::MaxBins));
   assign ncells = {1'b0, num_bins} + 10'd2;
   assign dx     = 17'(in_x) - 17'(x_min);
   assign span   = 17'(x_max) - 17'(x_min);
   assign trial  = {rem_ff, num_ff[DW-1]} - {{(DW+1-17){1'b0}}, den_ff};

   always_comb begin
      if ({1'b0, quo_ff} + 26'd1 >= 26'(ncells)) begin
         fbin = AW'(ncells - 10'd1);
      end else begin
         fbin = AW'(quo_ff + 25'd1);
      end
   end

   assign sum  = 33'(signed'(ram_rd)) + 33'(w_ff);
   assign satv = (sum > 33'sh07FFFFFFF) ? 32'sh7FFFFFFF :
                 (sum < -33'sh080000000) ? 32'sh80000000 : sum[31:0];

   assign sts.req      = req_ff;
   assign sts.early    = early_ff;
   assign sts.div_done = (step_ff == 5'(DW));
   assign sts.fill_bin = fbin;

   always_comb begin
      ram_we   = 1'b0;
      ram_addr = ctl.addr;
      ram_wd   = 32'd0;
      case (ctl.cmd)
         hist1d_pkg::CMD_FILLWR: begin
            ram_we = 1'b1; ram_wd = satv;
         end
         hist1d_pkg::CMD_SETWR: begin
            ram_we = 1'b1; ram_wd = sv_ff;
         end
         hist1d_pkg::CMD_CLRWR: begin
            ram_we = 1'b1;
         end
         default: ;
      endcase
   end

   hist1d_ram #(.Width(32), .Depth(hist1d_pkg::Cells)) u_ram (
      .clock(clock), .wr_en(ram_we), .addr(ram_addr),
      .wr_data(ram_wd), .rd_data(ram_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 32'd0;
         step_ff  <= 5'd0;
      end else begin
         case (ctl.cmd)
            hist1d_pkg::CMD_LOAD: begin
               req_ff <= in_req; w_ff <= in_w; idx_ff <= in_idx; sv_ff <= in_sv;
               num_ff <= DW'(num_bins) * DW'(unsigned'(dx[15:0]));
               den_ff <= 17'(unsigned'(span[15:0]));
               rem_ff <= '0; quo_ff <= '0; step_ff <= 5'd0;
               best_ff <= 32'sd0; best_bin_ff <= 9'd0; scan_ff <= '0;
               bin_ff <= 9'd0; content_ff <= 32'sd0; status_ff <= hist1d_pkg::ST_OK;
               early_ff <= 1'b1;
               if (in_req == hist1d_pkg::REQ_CLEAR) begin
                  early_ff <= 1'b0;
               end else if (in_req > hist1d_pkg::REQ_CLEAR) begin
                  status_ff <= hist1d_pkg::ST_RANGE;
               end else if (!nb_ok) begin
                  status_ff <= hist1d_pkg::ST_CFG;
               end else if (in_req == hist1d_pkg::REQ_FILL) begin
                  if (x_max <= x_min) begin
                     status_ff <= hist1d_pkg::ST_CFG;
                  end else if (in_x < x_min || in_x > x_max) begin
                     status_ff <= hist1d_pkg::ST_RANGE;
                  end else begin
                     early_ff <= 1'b0;
                  end
               end else if (in_req == hist1d_pkg::REQ_SET ||
                            in_req == hist1d_pkg::REQ_READ) begin
                  if ({1'b0, in_idx} >= ncells) begin
                     status_ff <= hist1d_pkg::ST_RANGE; bin_ff <= in_idx;
                  end else if (in_idx == 9'd0 && in_req == hist1d_pkg::REQ_SET) begin
                     status_ff <= hist1d_pkg::ST_RANGE;
                  end else begin
                     early_ff <= 1'b0;
                  end
               end else begin
                  early_ff <= 1'b0;
               end
            end
            hist1d_pkg::CMD_DIV: begin
               num_ff  <= num_ff << 1;
               step_ff <= step_ff + 5'd1;
               if (!trial[DW]) begin
                  rem_ff <= trial[DW-1:0]; quo_ff <= {quo_ff[DW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[DW-2:0], num_ff[DW-1]}; quo_ff <= {quo_ff[DW-2:0], 1'b0};
               end
            end
            hist1d_pkg::CMD_FILLWR: begin
               bin_ff <= 9'(fbin); content_ff <= satv;
               if (count_ff != 32'hFFFFFFFF) count_ff <= count_ff + 32'd1;
            end
            hist1d_pkg::CMD_SETWR: begin
               bin_ff <= idx_ff; content_ff <= sv_ff;
            end
            hist1d_pkg::CMD_READOUT: begin
               bin_ff <= idx_ff;
               content_ff <= (signed'(ram_rd) < threshold) ? 32'sd0 : ram_rd;
            end
            hist1d_pkg::CMD_MAXRD: begin
               // ram_rd holds the cell addressed last cycle
               if (signed'(ram_rd) > best_ff) begin
                  best_ff <= ram_rd; best_bin_ff <= 9'(scan_ff);
               end
               scan_ff <= scan_ff + AW'(1);
            end
            hist1d_pkg::CMD_DIRECT: begin
               if (req_ff == hist1d_pkg::REQ_MAX) begin
                  bin_ff <= best_bin_ff; content_ff <= best_ff;
               end
            end
            hist1d_pkg::CMD_CLRWR: begin
               count_ff <= 32'd0;
            end
            default: ;
         endcase
      end
   end

   assign out_bin     = bin_ff;
   assign out_content = content_ff;
   assign out_count   = count_ff;
   assign out_status  = status_ff;
endmodule

>>> rtl/core/hist1d_ctl.sv
// ----------------------------------------------------------------------------
// hist1d_ctl
// Controller: sequences each request through the datapath.
// ----------------------------------------------------------------------------
module hist1d_ctl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_fire,
   output logic                busy,
   output logic                rsp_load,
   input  logic                rsp_free,
   input  logic [8:0]          num_bins,
   input  logic [8:0]          idx,
   input  hist1d_pkg::sts_type sts,
   output hist1d_pkg::ctl_type ctl
);
   localparam int AW = hist1d_pkg::AddrW;
   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_DECODE, S_DIV, S_FRD, S_FWR, S_ACC, S_SCAN, S_CLR, S_DONE,
      S_HOLD
   } state_type;

   state_type     state_ff;
   logic [AW-1:0] addr_ff;
   logic [AW:0]   last;

   assign last = (AW+1)'(num_bins) + (AW+1)'(1);
   assign busy = (state_ff != S_IDLE);
   assign rsp_load = (state_ff == S_HOLD) && rsp_free;

   always_comb begin
      ctl.addr = addr_ff;
      ctl.cmd  = hist1d_pkg::CMD_NONE;
      case (state_ff)
         S_INIT:   ctl.cmd = hist1d_pkg::CMD_CLRWR;
         S_IDLE:   ctl.cmd = req_fire ? hist1d_pkg::CMD_LOAD : hist1d_pkg::CMD_NONE;
         S_DIV:    ctl.cmd = sts.div_done ? hist1d_pkg::CMD_NONE : hist1d_pkg::CMD_DIV;
         S_FRD:    ctl.addr = sts.fill_bin;
         S_FWR:    begin ctl.cmd = hist1d_pkg::CMD_FILLWR; ctl.addr = sts.fill_bin; end
         S_ACC:    ctl.cmd = hist1d_pkg::CMD_SETWR;
         S_SCAN:   ctl.cmd = (addr_ff != '0) ? hist1d_pkg::CMD_MAXRD : hist1d_pkg::CMD_NONE;
         S_CLR:    ctl.cmd = hist1d_pkg::CMD_CLRWR;
         S_DONE:   ctl.cmd = (sts.req == hist1d_pkg::REQ_READ && !sts.early) ?
                             hist1d_pkg::CMD_READOUT : hist1d_pkg::CMD_DIRECT;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         addr_ff  <= '0;
      end else begin
         case (state_ff)
            S_INIT: begin
               // zero every cell once after reset
               if (addr_ff == AW'(hist1d_pkg::Cells - 1)) state_ff <= S_IDLE;
               else addr_ff <= addr_ff + AW'(1);
            end
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_DECODE;
                  addr_ff  <= AW'(idx);
               end
            end
            S_DECODE: begin
               if (sts.early) state_ff <= S_DONE;
               else begin
                  case (sts.req)
                     hist1d_pkg::REQ_FILL:  state_ff <= S_DIV;
                     hist1d_pkg::REQ_SET:   state_ff <= S_ACC;
                     hist1d_pkg::REQ_READ:  state_ff <= S_DONE;
                     hist1d_pkg::REQ_MAX:   begin state_ff <= S_SCAN; addr_ff <= '0; end
                     hist1d_pkg::REQ_CLEAR: begin state_ff <= S_CLR; addr_ff <= '0; end
                     default:               state_ff <= S_DONE;
                  endcase
               end
            end
            S_DIV:  if (sts.div_done) state_ff <= S_FRD;
            S_FRD:  state_ff <= S_FWR;
            S_FWR:  state_ff <= S_HOLD;
            S_ACC:  state_ff <= S_HOLD;
            S_SCAN: begin
               // read address runs one past the last cell for the trailing compare
               if ((AW+1)'(addr_ff) == last + (AW+1)'(1)) state_ff <= S_DONE;
               else addr_ff <= addr_ff + AW'(1);
            end
            S_CLR: begin
               if (addr_ff == AW'(hist1d_pkg::Cells - 1)) state_ff <= S_HOLD;
               else addr_ff <= addr_ff + AW'(1);
            end
            S_DONE: state_ff <= S_HOLD;
            S_HOLD: if (rsp_free) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
